// ----- rtl/periodic_and_triggered_slot_scheduler_unit_defines.svh -----
// Assertion macros for the slot scheduler checker.
`ifndef PERIODIC_AND_TRIGGERED_SLOT_SCHEDULER_UNIT_DEFINES_SVH
`define PERIODIC_AND_TRIGGERED_SLOT_SCHEDULER_UNIT_DEFINES_SVH

// Property holds on every clock edge outside reset.
`define PTSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression never holds outside reset.
`define PTSS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ----- rtl/ptss_pkg.sv -----
// Shared types and constants for the slot scheduler.
package ptss_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int SLOT_MAX       = 32;
  localparam int FIRED_SLOT_W   = 5;

  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_REGISTER    = 3'd1,
    OP_UNREGISTER  = 3'd2,
    OP_TRIGGER     = 3'd3,
    OP_ENABLE      = 3'd4,
    OP_DISABLE     = 3'd5,
    OP_DISABLE_ALL = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_IN_USE  = 2'd2
  } status_e;

  localparam logic KIND_TRIG     = 1'b0;
  localparam logic KIND_PERIODIC = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TRIG,
    S_PER,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic exec;       // non-tick op applied this cycle
    logic tick_start; // tick accepted, reset scan index
    logic scan_trig;  // pending trigger pass
    logic scan_per;   // periodic pass
    logic flush;      // release held word with last set
  } cmd_t;

  typedef struct packed {
    logic idx_last;
  } sts_t;

endpackage

// ----- rtl/ptss_ctrl.sv -----
// Controller state machine for the slot scheduler.
module ptss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [2:0]        op_i,
  input  ptss_pkg::sts_t    sts_i,
  output ptss_pkg::cmd_t    cmd_o,
  output logic              busy
);

  ptss_pkg::state_e state_q, state_d;
  logic accept;

  assign accept = start && (state_q == ptss_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptss_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ptss_pkg::S_IDLE: begin
        if (accept && (op_i == ptss_pkg::OP_TICK)) state_d = ptss_pkg::S_TRIG;
      end
      ptss_pkg::S_TRIG: begin
        if (sts_i.idx_last) state_d = ptss_pkg::S_PER;
      end
      ptss_pkg::S_PER: begin
        if (sts_i.idx_last) state_d = ptss_pkg::S_FLUSH;
      end
      ptss_pkg::S_FLUSH: state_d = ptss_pkg::S_IDLE;
      default: state_d = ptss_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      ptss_pkg::S_IDLE: begin
        busy             = 1'b0;
        cmd_o.exec       = accept && (op_i != ptss_pkg::OP_TICK);
        cmd_o.tick_start = accept && (op_i == ptss_pkg::OP_TICK);
      end
      ptss_pkg::S_TRIG:  cmd_o.scan_trig = 1'b1;
      ptss_pkg::S_PER:   cmd_o.scan_per  = 1'b1;
      ptss_pkg::S_FLUSH: cmd_o.flush     = 1'b1;
      default: busy = 1'b0;
    endcase
  end

endmodule

// ----- rtl/ptss_datapath.sv -----
// Slot table, scan index and result register of the slot scheduler.
module ptss_datapath #(
  parameter int SlotCount = ptss_pkg::SLOT_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ptss_pkg::cmd_t                    cmd_i,
  output ptss_pkg::sts_t                    sts_o,
  input  logic [2:0]                        op_i,
  input  logic [7:0]                        slot_i,
  input  logic [15:0]                       period_ms_i,
  input  logic                              triggered_only_i,
  input  logic [31:0]                       now_ticks_i,
  output logic                              strobe_o,
  output logic [1:0]                        status_o,
  output logic                              fired_o,
  output logic [ptss_pkg::FIRED_SLOT_W-1:0] fired_slot_o,
  output logic                              fire_kind_o,
  output logic                              last_o
);

  localparam int IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  logic [SlotCount-1:0] reg_q, reg_d, en_q, en_d, pend_q, pend_d;
  logic                 tonly_q  [SlotCount];
  logic [15:0]          period_q [SlotCount];
  logic [31:0]          due_q    [SlotCount];
  logic [31:0]          now_q;
  logic [IdxW-1:0]      idx_q;
  logic [IdxW-1:0]      slot_idx;
  logic                 slot_ok;
  logic                 reg_wr;
  logic                 fire;
  logic                 fire_kind;
  ptss_pkg::status_e    exec_status;

  logic                 held_v_q;
  logic [IdxW-1:0]      held_slot_q;
  logic                 held_kind_q;

  logic                 out_v_q, out_v_d;
  ptss_pkg::status_e    out_status_q, out_status_d;
  logic                 out_fired_q, out_fired_d;
  logic [ptss_pkg::FIRED_SLOT_W-1:0] out_slot_q, out_slot_d;
  logic                 out_kind_q, out_kind_d;
  logic                 out_last_q, out_last_d;

  assign slot_ok   = ({1'b0, slot_i} < 9'(SlotCount));
  assign slot_idx  = slot_i[IdxW-1:0];
  assign sts_o.idx_last = (idx_q == IdxW'(SlotCount - 1));

  always_comb begin
    reg_d       = reg_q;
    en_d        = en_q;
    pend_d      = pend_q;
    reg_wr      = 1'b0;
    exec_status = ptss_pkg::ST_OK;
    fire        = 1'b0;
    fire_kind   = ptss_pkg::KIND_TRIG;
    if (cmd_i.exec) begin
      case (ptss_pkg::op_e'(op_i))
        ptss_pkg::OP_REGISTER: begin
          if (!slot_ok) exec_status = ptss_pkg::ST_INVALID;
          else if (reg_q[slot_idx]) exec_status = ptss_pkg::ST_IN_USE;
          else begin
            reg_wr          = 1'b1;
            reg_d[slot_idx] = 1'b1;
            en_d[slot_idx]  = 1'b0;
          end
        end
        ptss_pkg::OP_UNREGISTER: begin
          if (!slot_ok) exec_status = ptss_pkg::ST_INVALID;
          else begin
            reg_d[slot_idx] = 1'b0;
            en_d[slot_idx]  = 1'b0;
          end
        end
        ptss_pkg::OP_TRIGGER: begin
          if (!slot_ok) exec_status = ptss_pkg::ST_INVALID;
          else pend_d[slot_idx] = 1'b1;
        end
        ptss_pkg::OP_ENABLE: begin
          if (!slot_ok) exec_status = ptss_pkg::ST_INVALID;
          else en_d[slot_idx] = 1'b1;
        end
        ptss_pkg::OP_DISABLE: begin
          if (!slot_ok) exec_status = ptss_pkg::ST_INVALID;
          else en_d[slot_idx] = 1'b0;
        end
        ptss_pkg::OP_DISABLE_ALL: en_d = '0;
        default: exec_status = ptss_pkg::ST_INVALID;
      endcase
    end
    if (cmd_i.scan_trig && pend_q[idx_q]) begin
      pend_d[idx_q] = 1'b0;
      fire          = reg_q[idx_q];
    end
    if (cmd_i.scan_per) begin
      fire      = en_q[idx_q] && reg_q[idx_q] && !tonly_q[idx_q] && (due_q[idx_q] <= now_q);
      fire_kind = ptss_pkg::KIND_PERIODIC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q    <= '0;
      en_q     <= '0;
      pend_q   <= '0;
      idx_q    <= '0;
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      reg_q   <= reg_d;
      en_q    <= en_d;
      pend_q  <= pend_d;
      out_v_q <= out_v_d;
      if (cmd_i.tick_start) idx_q <= '0;
      else if (cmd_i.scan_trig || cmd_i.scan_per) begin
        idx_q <= sts_o.idx_last ? '0 : idx_q + 1'b1;
      end
      if (fire) held_v_q <= 1'b1;
      else if (cmd_i.flush) held_v_q <= 1'b0;
    end
  end

  // table payload, defined by register before any use
  always_ff @(posedge clk_i) begin
    if (reg_wr) begin
      period_q[slot_idx] <= period_ms_i;
      tonly_q[slot_idx]  <= triggered_only_i;
      due_q[slot_idx]    <= '0;
    end else if (fire && cmd_i.scan_per) begin
      due_q[idx_q] <= due_q[idx_q] + 32'(period_q[idx_q]);
    end
    if (cmd_i.tick_start) now_q <= now_ticks_i;
    if (fire) begin
      held_slot_q <= idx_q;
      held_kind_q <= fire_kind;
    end
  end

  // held firing goes out once the next one is known, or at flush with last set
  always_comb begin
    out_v_d      = 1'b0;
    out_status_d = ptss_pkg::ST_OK;
    out_fired_d  = 1'b1;
    out_slot_d   = ptss_pkg::FIRED_SLOT_W'(held_slot_q);
    out_kind_d   = held_kind_q;
    out_last_d   = 1'b0;
    if (cmd_i.exec) begin
      out_v_d      = 1'b1;
      out_status_d = exec_status;
      out_fired_d  = 1'b0;
      out_slot_d   = '0;
      out_kind_d   = ptss_pkg::KIND_TRIG;
      out_last_d   = 1'b1;
    end else if (fire && held_v_q) begin
      out_v_d = 1'b1;
    end else if (cmd_i.flush && held_v_q) begin
      out_v_d    = 1'b1;
      out_last_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_d) begin
      out_status_q <= out_status_d;
      out_fired_q  <= out_fired_d;
      out_slot_q   <= out_slot_d;
      out_kind_q   <= out_kind_d;
      out_last_q   <= out_last_d;
    end
  end

  assign strobe_o     = out_v_q;
  assign status_o     = out_status_q;
  assign fired_o      = out_fired_q;
  assign fired_slot_o = out_slot_q;
  assign fire_kind_o  = out_kind_q;
  assign last_o       = out_last_q;

endmodule

// ----- rtl/periodic_and_triggered_slot_scheduler_unit.sv -----
// Top level of the periodic and triggered slot scheduler.
// Non-tick ops: status word in the cycle after acceptance; busy stays low, one op per cycle.
// Tick: busy while the controller steps one slot per cycle through the trigger pass,
// then the periodic pass, then a flush state; each fired word is held until the next one.
// Fired words appear one per cycle at most; the word with last set follows the flush cycle.
// Asynchronous active-low reset clears the slot flags, pending triggers and the controller.
module periodic_and_triggered_slot_scheduler_unit #(
  parameter int SlotCount = ptss_pkg::SLOT_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        op_i,
  input  logic [7:0]                        slot_i,
  input  logic [15:0]                       period_ms_i,
  input  logic                              triggered_only_i,
  input  logic [31:0]                       now_ticks_i,
  output logic                              strobe_o,
  output logic [1:0]                        status_o,
  output logic                              fired_o,
  output logic [ptss_pkg::FIRED_SLOT_W-1:0] fired_slot_o,
  output logic                              fire_kind_o,
  output logic                              last_o
);

  ptss_pkg::cmd_t cmd;
  ptss_pkg::sts_t sts;

  ptss_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  ptss_datapath #(
    .SlotCount (SlotCount)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (op_i),
    .slot_i           (slot_i),
    .period_ms_i      (period_ms_i),
    .triggered_only_i (triggered_only_i),
    .now_ticks_i      (now_ticks_i),
    .strobe_o         (strobe_o),
    .status_o         (status_o),
    .fired_o          (fired_o),
    .fired_slot_o     (fired_slot_o),
    .fire_kind_o      (fire_kind_o),
    .last_o           (last_o)
  );

endmodule

// ----- rtl/ptss_checker.sv -----
// Port-level assertions for the slot scheduler, bound to the top level.
`include "periodic_and_triggered_slot_scheduler_unit_defines.svh"

module ptss_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic [2:0]                        op_i,
  input logic                              strobe_o,
  input logic [1:0]                        status_o,
  input logic                              fired_o,
  input logic [ptss_pkg::FIRED_SLOT_W-1:0] fired_slot_o,
  input logic                              fire_kind_o,
  input logic                              last_o
);

  `PTSS_ASSERT(a_status_word, strobe_o && !fired_o |-> last_o && fired_slot_o == '0 && fire_kind_o == ptss_pkg::KIND_TRIG, "status word malformed")
  `PTSS_ASSERT(a_fired_ok, strobe_o && fired_o |-> status_o == ptss_pkg::ST_OK, "fired word with non-ok status")
  `PTSS_ASSERT(a_op_answer, start && !busy && op_i != ptss_pkg::OP_TICK |=> strobe_o && !fired_o && !busy, "op not answered next cycle")
  `PTSS_ASSERT(a_tick_busy, start && !busy && op_i == ptss_pkg::OP_TICK |=> busy, "tick did not raise busy")
  `PTSS_ASSERT_NEVER(a_fired_idle, strobe_o && fired_o && !busy && !last_o && !$past(busy), "fired word outside a tick")

endmodule

bind periodic_and_triggered_slot_scheduler_unit ptss_checker u_ptss_checker (.*);

// ----- dv/periodic_and_triggered_slot_scheduler_unit_checker.sv -----
// Checker for the slot scheduler: tracks the slot table and compares every word.
`timescale 1ns / 100ps

module periodic_and_triggered_slot_scheduler_unit_checker
  import ptss_pkg::*;
#(
  parameter int SlotCount = SLOT_COUNT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  logic [2:0]              op_i,
  input  logic [7:0]              slot_i,
  input  logic [15:0]             period_ms_i,
  input  logic                    triggered_only_i,
  input  logic [31:0]             now_ticks_i,
  input  logic                    strobe_i,
  input  logic [1:0]              status_i,
  input  logic                    fired_i,
  input  logic [FIRED_SLOT_W-1:0] fired_slot_i,
  input  logic                    fire_kind_i,
  input  logic                    last_i,
  output int                      fail_count_o,
  output int                      words_open_o,
  output int                      fires_o
);

  typedef struct packed {
    status_e                 status;
    logic                    fired;
    logic [FIRED_SLOT_W-1:0] fired_slot;
    logic                    fire_kind;
    logic                    last;
  } sched_word_t;

  logic [SlotCount-1:0] slot_reg;
  logic [SlotCount-1:0] slot_en;
  logic [SlotCount-1:0] slot_tonly;
  logic [SlotCount-1:0] trig_pending;
  logic [15:0]          slot_period [SlotCount];
  logic [31:0]          slot_due    [SlotCount];

  sched_word_t sched_word_q[$];
  int          fails;
  int          fires;

  task automatic step_slot_table(input logic [2:0] op, input logic [7:0] slot,
                                 input logic [15:0] period, input logic tonly,
                                 input logic [31:0] now);
    sched_word_t w;
    status_e     st;
    int          n;
    logic        valid;
    valid = slot < SlotCount;
    n     = 0;
    st    = ST_OK;
    if (op == OP_TICK) begin
      for (int i = 0; i < SlotCount; i++) begin
        if (trig_pending[i]) begin
          trig_pending[i] = 1'b0;
          if (slot_reg[i]) begin
            w = '{status: ST_OK, fired: 1'b1, fired_slot: FIRED_SLOT_W'(i),
                  fire_kind: KIND_TRIG, last: 1'b0};
            sched_word_q.push_back(w);
            n++;
          end
        end
      end
      for (int i = 0; i < SlotCount; i++) begin
        if (slot_en[i] && slot_reg[i] && !slot_tonly[i] && slot_due[i] <= now) begin
          w = '{status: ST_OK, fired: 1'b1, fired_slot: FIRED_SLOT_W'(i),
                fire_kind: KIND_PERIODIC, last: 1'b0};
          sched_word_q.push_back(w);
          slot_due[i] = slot_due[i] + 32'(slot_period[i]);
          n++;
        end
      end
      if (n > 0) sched_word_q[sched_word_q.size()-1].last = 1'b1;
    end else begin
      case (op)
        OP_REGISTER: begin
          if (!valid) st = ST_INVALID;
          else if (slot_reg[slot]) st = ST_IN_USE;
          else begin
            slot_reg[slot]    = 1'b1;
            slot_period[slot] = period;
            slot_tonly[slot]  = tonly;
            slot_en[slot]     = 1'b0;
            slot_due[slot]    = '0;
          end
        end
        OP_UNREGISTER: begin
          if (!valid) st = ST_INVALID;
          else begin
            slot_reg[slot] = 1'b0;
            slot_en[slot]  = 1'b0;
          end
        end
        OP_TRIGGER: begin
          if (!valid) st = ST_INVALID;
          else trig_pending[slot] = 1'b1;
        end
        OP_ENABLE: begin
          if (!valid) st = ST_INVALID;
          else slot_en[slot] = 1'b1;
        end
        OP_DISABLE: begin
          if (!valid) st = ST_INVALID;
          else slot_en[slot] = 1'b0;
        end
        OP_DISABLE_ALL: slot_en = '0;
        default: st = ST_INVALID;
      endcase
      w = '{status: st, fired: 1'b0, fired_slot: '0, fire_kind: KIND_TRIG, last: 1'b1};
      sched_word_q.push_back(w);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sched_word_t w;
    if (!rst_ni) begin
      slot_reg     = '0;
      slot_en      = '0;
      slot_tonly   = '0;
      trig_pending = '0;
      for (int i = 0; i < SlotCount; i++) begin
        slot_period[i] = '0;
        slot_due[i]    = '0;
      end
      sched_word_q.delete();
      fails = 0;
      fires = 0;
    end else begin
      // results first: a word strobed now belongs to an earlier command
      if (strobe_i === 1'b1) begin
        if (fired_i === 1'b1) fires++;
        if (sched_word_q.size() == 0) begin
          $error("unexpected word: status %0d fired %0d slot %0d kind %0d last %0d",
                 status_i, fired_i, fired_slot_i, fire_kind_i, last_i);
          fails++;
        end else begin
          w = sched_word_q.pop_front();
          if (status_i !== w.status) begin
            $error("status: expected %0d, got %0d", w.status, status_i);
            fails++;
          end
          if (fired_i !== w.fired) begin
            $error("fired: expected %0d, got %0d", w.fired, fired_i);
            fails++;
          end
          if (fired_slot_i !== w.fired_slot) begin
            $error("fired_slot: expected %0d, got %0d", w.fired_slot, fired_slot_i);
            fails++;
          end
          if (fire_kind_i !== w.fire_kind) begin
            $error("fire_kind: expected %0d, got %0d", w.fire_kind, fire_kind_i);
            fails++;
          end
          if (last_i !== w.last) begin
            $error("last: expected %0d, got %0d", w.last, last_i);
            fails++;
          end
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        step_slot_table(op_i, slot_i, period_ms_i, triggered_only_i, now_ticks_i);
      end
    end
    fail_count_o <= fails;
    words_open_o <= sched_word_q.size();
    fires_o      <= fires;
  end

endmodule

// ----- dv/periodic_and_triggered_slot_scheduler_unit_tb.sv -----
// Testbench top for the slot scheduler: command stimulus, reset, clock and verdict.
`timescale 1ns / 100ps

module periodic_and_triggered_slot_scheduler_unit_tb;
  import ptss_pkg::*;

  localparam int         SLOTS       = SLOT_COUNT_DEF;
  localparam int         RAND_WORDS  = 400;
  localparam int         DRAIN_AT    = 200;
  localparam logic [2:0] OP_UNUSED   = 3'd7;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [2:0]              op_i;
  logic [7:0]              slot_i;
  logic [15:0]             period_ms_i;
  logic                    triggered_only_i;
  logic [31:0]             now_ticks_i;
  logic                    strobe_o;
  logic [1:0]              status_o;
  logic                    fired_o;
  logic [FIRED_SLOT_W-1:0] fired_slot_o;
  logic                    fire_kind_o;
  logic                    last_o;

  int fail_count;
  int words_open;
  int fires;
  int n_words;
  int n_ticks;

  periodic_and_triggered_slot_scheduler_unit #(
    .SlotCount(SLOTS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .slot_i          (slot_i),
    .period_ms_i     (period_ms_i),
    .triggered_only_i(triggered_only_i),
    .now_ticks_i     (now_ticks_i),
    .strobe_o        (strobe_o),
    .status_o        (status_o),
    .fired_o         (fired_o),
    .fired_slot_o    (fired_slot_o),
    .fire_kind_o     (fire_kind_o),
    .last_o          (last_o)
  );

  periodic_and_triggered_slot_scheduler_unit_checker #(
    .SlotCount(SLOTS)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .op_i            (op_i),
    .slot_i          (slot_i),
    .period_ms_i     (period_ms_i),
    .triggered_only_i(triggered_only_i),
    .now_ticks_i     (now_ticks_i),
    .strobe_i        (strobe_o),
    .status_i        (status_o),
    .fired_i         (fired_o),
    .fired_slot_i    (fired_slot_o),
    .fire_kind_i     (fire_kind_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .words_open_o    (words_open),
    .fires_o         (fires)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // start stays high across back-to-back words; lowered only for a gap
  task automatic issue_word(input logic [2:0] op, input logic [7:0] slot,
                            input logic [15:0] period, input logic tonly,
                            input logic [31:0] now, input int gap);
    op_i             <= op;
    slot_i           <= slot;
    period_ms_i      <= period;
    triggered_only_i <= tonly;
    now_ticks_i      <= now;
    start            <= 1'b1;
    do @(posedge clk_i); while (busy);
    n_words++;
    if (op == OP_TICK) n_ticks++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    logic [31:0] time_now;
    logic [2:0]  op;
    logic [7:0]  slot;
    logic [15:0] period;
    logic [31:0] now;
    int          r;
    int          gap;
    n_words          = 0;
    n_ticks          = 0;
    time_now         = '0;
    rst_ni           <= 1'b0;
    start            <= 1'b0;
    op_i             <= OP_TICK;
    slot_i           <= '0;
    period_ms_i      <= '0;
    triggered_only_i <= 1'b0;
    now_ticks_i      <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    issue_word(OP_REGISTER,    8'd0,   16'd0,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_REGISTER,    8'd31,  16'hFFFF,   1'b1, 32'd0,          pick_gap(0));
    issue_word(OP_REGISTER,    8'd31,  16'd5,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_REGISTER,    8'd32,  16'd3,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_REGISTER,    8'd255, 16'd3,      1'b1, 32'd0,          pick_gap(0));
    issue_word(OP_ENABLE,      8'd0,   16'd0,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_ENABLE,      8'd31,  16'd0,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_ENABLE,      8'd255, 16'd0,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_TRIGGER,     8'd31,  16'd0,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_TRIGGER,     8'd5,   16'd0,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_TICK,        8'd0,   16'd0,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_REGISTER,    8'd1,   16'hFFFF,   1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_ENABLE,      8'd1,   16'd0,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_TICK,        8'd0,   16'd0,      1'b0, 32'hFFFF_FFFF,  pick_gap(0));
    issue_word(OP_TICK,        8'd0,   16'd0,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_DISABLE,     8'd0,   16'd0,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_DISABLE,     8'd40,  16'd0,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_UNREGISTER,  8'd1,   16'd0,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_UNREGISTER,  8'd200, 16'd0,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_TRIGGER,     8'd1,   16'd0,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_TRIGGER,     8'd31,  16'd0,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_TICK,        8'd0,   16'd0,      1'b0, 32'd100,        pick_gap(0));
    issue_word(OP_DISABLE_ALL, 8'd255, 16'd0,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_UNUSED,      8'd3,   16'd0,      1'b0, 32'd0,          pick_gap(0));
    issue_word(OP_TICK,        8'd0,   16'd0,      1'b0, 32'h8000_0000,  pick_gap(0));

    for (int i = 0; i < RAND_WORDS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30)      op = OP_TICK;
      else if (r < 50) op = OP_REGISTER;
      else if (r < 58) op = OP_UNREGISTER;
      else if (r < 70) op = OP_TRIGGER;
      else if (r < 85) op = OP_ENABLE;
      else if (r < 91) op = OP_DISABLE;
      else if (r < 96) op = OP_DISABLE_ALL;
      else             op = OP_UNUSED;
      slot   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(SLOTS, 255))
                                           : 8'($urandom_range(0, SLOTS - 1));
      period = ($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
      now    = $urandom;
      if (op == OP_TICK) begin
        r = $urandom_range(0, 99);
        if (r < 85)      time_now = time_now + 32'($urandom_range(0, 6));
        else if (r < 95) time_now = $urandom;
        now = time_now;
      end
      gap = (i == DRAIN_AT || i == RAND_WORDS - 1) ? 0 : pick_gap((i % 80) < 20);
      issue_word(op, slot, period, ($urandom_range(0, 3) == 0), now, gap);
      if (i == DRAIN_AT) begin
        start <= 1'b0;
        do @(posedge clk_i); while (words_open != 0 || busy);
      end
    end
    start <= 1'b0;

    do @(posedge clk_i); while (words_open != 0 || busy);
    repeat (2 * SLOTS + 8) @(posedge clk_i);

    if (words_open != 0) $error("%0d expected words never arrived", words_open);
    $display("Run covered %0d command words (%0d ticks) and %0d slot firings.",
             n_words, n_ticks, fires);
    if (fail_count == 0 && words_open == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
